### hw/rtl/dfa_string_matcher_top_assert.svh
// ---------------------------------------------------------------------------
// dfa_string_matcher_top_assert.svh: assertion macros for the string matcher
// Shared wrappers that clock assertions on clk and disable them during reset.
// ---------------------------------------------------------------------------
`ifndef DFA_STRING_MATCHER_TOP_ASSERT_SVH
`define DFA_STRING_MATCHER_TOP_ASSERT_SVH

// Same-cycle implication.
`define DSM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define DSM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/dsm_pkg.sv
// ---------------------------------------------------------------------------
// dsm_pkg: shared types and constants of the string matcher
// Payload structs, register codes, cell control and pattern byte lookup.
// ---------------------------------------------------------------------------
package dsm_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 64;
	localparam int LEN_BITS       = 5;
	localparam int PATTERN_BYTES  = 16;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LOW    = 2'd0,
		REG_PATTERN_HIGH   = 2'd1,
		REG_PATTERN_LENGTH = 2'd2
	} dsm_reg_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       start_of_text;
	} dsm_in_t;

	typedef struct packed {
		logic                match_found;
		logic [31:0]         match_start;
		logic [LEN_BITS-1:0] prefix_matched;
	} dsm_out_t;

	// Control broadcast to every cell of the row.
	typedef struct packed {
		logic shift;
		logic clear;
	} dsm_cell_ctl_t;

	// Pattern byte idx of the two pattern registers; bytes past the registers read as zero.
	function automatic logic [7:0] pat_byte(input logic [CFG_DATA_BITS-1:0] lo,
		input logic [CFG_DATA_BITS-1:0] hi, input int idx);
		logic [2*CFG_DATA_BITS-1:0] both;
		both = {hi, lo};
		if (idx < PATTERN_BYTES) begin
			return both[idx*8 +: 8];
		end
		return 8'd0;
	endfunction

endpackage

### hw/rtl/dsm_cell.sv
// ---------------------------------------------------------------------------
// dsm_cell: one prefix cell of the matcher row
// Holds whether the pattern prefix ending at this cell is a suffix of the text.
// ---------------------------------------------------------------------------
module dsm_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dsm_pkg::dsm_cell_ctl_t ctl,
	input  logic [7:0]            text_byte,
	input  logic [7:0]            pattern_byte,
	input  logic                  enable,
	input  logic                  left_hit,
	output logic                  hit
);
	import dsm_pkg::*;

	logic hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (ctl.shift) begin
			// The prefix one shorter must have matched and this byte must extend it.
			hit_q <= left_hit & enable & (pattern_byte == text_byte);
		end
	end

	assign hit = hit_q;

endmodule

### hw/rtl/dsm_result.sv
// ---------------------------------------------------------------------------
// dsm_result: state encoder and output register
// Picks the longest matched prefix from the cell row and registers the result.
// ---------------------------------------------------------------------------
module dsm_result #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32,
	parameter int LW          = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [MAX_PATTERN-1:0] cell_hit,
	input  logic [LW-1:0]          eff_len,
	input  logic [OFFSET_BITS-1:0] cur_s1,
	input  logic                   valid_s1,
	output logic                   advance,
	output logic [LW-1:0]          state_next,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dsm_pkg::dsm_out_t      out_data
);
	import dsm_pkg::*;

	logic     out_valid_q;
	dsm_out_t out_q;
	dsm_out_t res;
	logic [31:0] cur32;

	always_comb begin
		state_next = '0;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (cell_hit[i]) begin
				state_next = LW'(i + 1);
			end
		end
	end

	always_comb begin
		cur32              = 32'(cur_s1);
		res.match_found    = (state_next == eff_len);
		res.match_start    = res.match_found ? (cur32 + 32'd1 - 32'(eff_len)) : 32'd0;
		res.prefix_matched = LEN_BITS'(state_next);
	end

	assign advance = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

### hw/rtl/dfa_string_matcher_top.sv
// A result is registered first in the cell row, then in the output register.
// Throughput: one text byte per cycle, set by the row of prefix cells that all update at once,
// while no rebuild or output back-pressure holds in_ready low. A configuration write rebuilds
// the row by replaying up to min(state, length) pattern bytes, one per cycle, with in_ready low.
// Reset: asynchronous, active low; clears state, offset, pattern and sets the length to one.
// ---------------------------------------------------------------------------
// dfa_string_matcher_top: streaming finite-automaton string matcher
// Row of prefix cells tracks every pattern prefix that ends the text so far.
// ---------------------------------------------------------------------------
`include "dfa_string_matcher_top_assert.svh"

module dfa_string_matcher_top #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  dsm_pkg::dsm_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output dsm_pkg::dsm_out_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dsm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dsm_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import dsm_pkg::*;

	localparam int LW = $clog2(MAX_PATTERN + 1);

	logic [CFG_DATA_BITS-1:0] pat_lo_q;
	logic [CFG_DATA_BITS-1:0] pat_hi_q;
	logic [LEN_BITS-1:0]      pat_len_q;

	logic [LW-1:0]          eff_len;
	logic [MAX_PATTERN-1:0] len_mask;
	logic [MAX_PATTERN-1:0] cell_hit;
	logic [MAX_PATTERN-1:0] left_hit;

	logic [LW-1:0]          state_q;
	logic [LW-1:0]          state_next;
	logic [OFFSET_BITS-1:0] offset_q;
	logic [OFFSET_BITS-1:0] cur;
	logic [OFFSET_BITS-1:0] cur_s1;
	logic                   valid_s1;
	logic                   advance;

	logic          resync_q;
	logic [LW-1:0] cnt_q;
	logic [LW-1:0] resync_target;
	logic          resync_feed;
	logic [7:0]    feed_byte;
	logic [7:0]    cell_byte;

	logic          in_accept;
	logic          cfg_we;
	dsm_cell_ctl_t cell_ctl;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q  <= '0;
			pat_hi_q  <= '0;
			pat_len_q <= LEN_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PATTERN_LOW:    pat_lo_q  <= cfg_data;
				REG_PATTERN_HIGH:   pat_hi_q  <= cfg_data;
				REG_PATTERN_LENGTH: pat_len_q <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// A zero length counts as one, and a length past the row is cut to the row.
	always_comb begin
		if (pat_len_q == '0) begin
			eff_len = LW'(1);
		end else if (int'(pat_len_q) > MAX_PATTERN) begin
			eff_len = LW'(MAX_PATTERN);
		end else begin
			eff_len = LW'(pat_len_q);
		end
		for (int k = 0; k < MAX_PATTERN; k++) begin
			len_mask[k] = (k + 1 <= int'(eff_len));
		end
	end

	// Rebuild of the row after a configuration write: replaying the first
	// min(state, length) pattern bytes leaves exactly the prefixes of that state.
	assign resync_target = (state_q > eff_len) ? eff_len : state_q;
	assign resync_feed   = resync_q && !valid_s1 && (cnt_q < resync_target);
	assign feed_byte     = pat_byte(pat_lo_q, pat_hi_q, int'(cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resync_q <= 1'b0;
			cnt_q    <= '0;
		end else if (cfg_we) begin
			resync_q <= 1'b1;
			cnt_q    <= '0;
		end else if (resync_feed) begin
			cnt_q <= cnt_q + LW'(1);
		end else if (resync_q && !valid_s1) begin
			resync_q <= 1'b0;
		end
	end

	// Input side.
	assign in_ready  = !resync_q && (!valid_s1 || advance);
	assign in_accept = in_valid && in_ready;

	assign cur = in_data.start_of_text ? '0 : offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			valid_s1 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (in_accept) begin
				offset_q <= (cur == '1) ? cur : cur + OFFSET_BITS'(1);
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && advance) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cur_s1 <= cur;
		end
	end

	// Cell row.
	always_comb begin
		cell_ctl.shift = in_accept || resync_feed;
		cell_ctl.clear = cfg_we;
		cell_byte      = in_accept ? in_data.text_byte : feed_byte;
	end

	// The empty prefix always matches; a start of text drops every longer one.
	always_comb begin
		left_hit[0] = 1'b1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			left_hit[k] = cell_hit[k-1] && !(in_accept && in_data.start_of_text);
		end
	end

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		dsm_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (cell_ctl),
			.text_byte    (cell_byte),
			.pattern_byte (pat_byte(pat_lo_q, pat_hi_q, k)),
			.enable       (len_mask[k]),
			.left_hit     (left_hit[k]),
			.hit          (cell_hit[k])
		);
	end

	dsm_result #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_BITS (OFFSET_BITS),
		.LW          (LW)
	) u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_hit   (cell_hit),
		.eff_len    (eff_len),
		.cur_s1     (cur_s1),
		.valid_s1   (valid_s1),
		.advance    (advance),
		.state_next (state_next),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

	`DSM_ASSERT_NOW(a_match_at_full_length, out_valid && out_data.match_found, out_data.prefix_matched == LEN_BITS'(eff_len), "match reported at a state other than the pattern length")
	`DSM_ASSERT_NOW(a_no_hit_past_length, !resync_q && !cfg_valid, (cell_hit & ~len_mask) == '0, "cell past the pattern length holds a hit")
	`DSM_ASSERT_NOW(a_resync_bounded, resync_q, cnt_q <= resync_target, "rebuild replayed more bytes than the state holds")
	`DSM_ASSERT_NEXT(a_cfg_starts_resync, cfg_valid && cfg_ready, resync_q && (cnt_q == '0), "configuration write did not restart the rebuild")

endmodule

### test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench of the streaming string matcher
// Streams text bytes through dfa_string_matcher_top under a series of pattern
// settings, predicts the automaton state, match flag and start offset of every
// byte, and compares each result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module tb_top;
	import dsm_pkg::*;

	class match_scoreboard;
		bit [63:0]   pat_lo;
		bit [63:0]   pat_hi;
		bit [4:0]    len_code;
		int unsigned prefix_state;
		bit [31:0]   text_offset;
		dsm_out_t    awaited[$];
		int          mismatches;
		int          noted;
		int          checked;
		int          found;

		function new();
			pat_lo = '0;
			pat_hi = '0;
			len_code = 5'd1;
			prefix_state = 0;
			text_offset = '0;
		endfunction

		function void write_reg(input dsm_reg_t idx, input logic [63:0] value);
			case (idx)
				REG_PATTERN_LOW: pat_lo = value;
				REG_PATTERN_HIGH: pat_hi = value;
				REG_PATTERN_LENGTH: len_code = value[4:0];
				default: ;
			endcase
		endfunction

		// A zero length acts as one, and lengths past the cell row saturate.
		function int unsigned active_length();
			if (len_code == 0) return 1;
			if (len_code > PATTERN_BYTES) return PATTERN_BYTES;
			return 32'(len_code);
		endfunction

		function logic [7:0] pattern_at(input int unsigned idx);
			if (idx < 8) return pat_lo[8*idx +: 8];
			if (idx < 16) return pat_hi[8*(idx-8) +: 8];
			return 8'h00;
		endfunction

		// Longest prefix of length k <= q+1 whose last byte is c and whose first k-1
		// bytes end the current prefix of length q.
		function int unsigned advance_automaton(input int unsigned q, input logic [7:0] c,
			input int unsigned len);
			int unsigned k;
			int unsigned i;
			bit fits;
			k = (q + 1 < len) ? q + 1 : len;
			while (k > 0) begin
				fits = (pattern_at(k - 1) == c);
				i = 0;
				while (fits && i + 1 < k) begin
					if (pattern_at(i) != pattern_at(q + 1 - k + i)) fits = 1'b0;
					i++;
				end
				if (fits) return k;
				k--;
			end
			return 0;
		endfunction

		function void note_byte(input dsm_in_t item);
			int unsigned len;
			int unsigned q;
			dsm_out_t want;
			len = active_length();
			if (item.start_of_text) begin
				prefix_state = 0;
				text_offset = '0;
			end
			// A state left over from a longer pattern counts as a full match of the new one.
			q = (prefix_state > len) ? len : prefix_state;
			q = advance_automaton(q, item.text_byte, len);
			prefix_state = q;
			want.match_found = (q == len);
			want.match_start = (q == len) ? text_offset + 32'd1 - 32'(len) : 32'd0;
			want.prefix_matched = 5'(q);
			if (text_offset != '1) text_offset++;
			awaited.push_back(want);
			noted++;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		task report(input string line);
			mismatches++;
			$display("MISMATCH %s", line);
		endtask

		task check_result(input dsm_out_t got);
			dsm_out_t want;
			checked++;
			if (awaited.size() == 0) begin
				report($sformatf("result %0d arrived with no byte awaiting it", checked));
				return;
			end
			want = awaited.pop_front();
			if (want.match_found) found++;
			if (got.match_found !== want.match_found)
				report($sformatf("result %0d: match_found %b, expected %b", checked,
					got.match_found, want.match_found));
			if (got.match_start !== want.match_start)
				report($sformatf("result %0d: match_start %h, expected %h", checked,
					got.match_start, want.match_start));
			if (got.prefix_matched !== want.prefix_matched)
				report($sformatf("result %0d: prefix_matched %0d, expected %0d", checked,
					got.prefix_matched, want.prefix_matched));
		endtask
	endclass

	localparam int IDLE_PERCENT   = 28;
	localparam int START_PERCENT  = 2;
	localparam int RANDOM_PHASES  = 12;
	localparam int PHASE_BYTES    = 165;
	localparam int HOLD_CYCLES    = 120;
	localparam int SETTLE_CYCLES  = 8;
	localparam int CYCLE_LIMIT    = 400000;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	dsm_in_t                    in_data = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	dsm_out_t                   out_data;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

	bit steady_flow = 1'b0;
	bit hold_request = 1'b0;
	int reg_writes = 0;
	int cycle_count = 0;
	match_scoreboard board = new();

	dfa_string_matcher_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
			board.pending());
		$display("== FAIL ==");
		$finish;
	end

	// Result side: checks every transfer, stalls at random, and once holds off long
	// enough for the matcher to fill up and stall its input.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) board.check_result(out_data);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	task automatic send_byte(input logic [7:0] value, input bit restart);
		if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PERCENT);
		end
		in_valid <= 1'b1;
		in_data.text_byte <= value;
		in_data.start_of_text <= restart;
		@(posedge clk);
		while (in_ready !== 1'b1) @(posedge clk);
		board.note_byte({value, restart});
	endtask

	// Stops offering bytes and waits until every predicted result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that back-to-back writes do not toggle it.
	task automatic write_register(input dsm_reg_t idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		board.write_reg(idx, value);
		reg_writes++;
	endtask

	task automatic load_pattern(input bit set_low, input bit set_high, input bit set_length,
		input logic [63:0] lo, input logic [63:0] hi, input logic [63:0] len_word);
		settle();
		if (set_low) write_register(REG_PATTERN_LOW, lo);
		if (set_high) write_register(REG_PATTERN_HIGH, hi);
		if (set_length) write_register(REG_PATTERN_LENGTH, len_word);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int          sent;
		int          pick;
		int          span;
		int unsigned len;
		int unsigned len_pick;
		int          alphabet;
		bit          paused;
		logic [7:0]  sym [3];
		logic [7:0]  b;
		logic [127:0] bytes_all;
		logic [63:0] len_word;
		bit [2:0]    which;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Power-on pattern is a single zero byte.
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);

		// A length of zero behaves as one.
		load_pattern(1'b1, 1'b0, 1'b1, '1, '0, 64'd0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFE, 1'b0);
		send_byte(8'hFF, 1'b0);

		// Overlapping prefixes force the automaton to fall back.
		load_pattern(1'b1, 1'b0, 1'b1, 64'h0000_0000_0062_6161, '0, 64'd3);
		send_byte(8'h61, 1'b1);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);

		// Shrinking the length mid-text leaves a state above the new length.
		load_pattern(1'b0, 1'b0, 1'b1, '0, '0, 64'd2);
		send_byte(8'h61, 1'b0);
		send_byte(8'h62, 1'b0);

		// An overlong length saturates to the full sixteen bytes.
		load_pattern(1'b1, 1'b1, 1'b1, '0, '1, 64'd31);
		send_byte(8'h00, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			alphabet = ($urandom_range(99) < 65) ? $urandom_range(3, 2) : 0;
			for (int s = 0; s < 3; s++) sym[s] = 8'($urandom_range(255));
			for (int j = 0; j < 16; j++)
				bytes_all[8*j +: 8] = alphabet ? sym[$urandom_range(alphabet - 1)]
					: 8'($urandom_range(255));
			if (phase == 0) len_pick = 16;
			else if (phase == 1) len_pick = 1;
			else begin
				pick = $urandom_range(99);
				if (pick < 6) len_pick = 0;
				else if (pick < 12) len_pick = $urandom_range(31, 17);
				else if (pick < 50) len_pick = $urandom_range(4, 1);
				else if (pick < 80) len_pick = $urandom_range(8, 5);
				else len_pick = $urandom_range(16, 9);
			end
			// Upper bits of the length word are ignored by the matcher.
			len_word = {$urandom, $urandom};
			len_word[4:0] = len_pick[4:0];
			pick = $urandom_range(99);
			if (phase < 2 || pick < 60) which = 3'b111;
			else if (pick < 85) which = 3'b100;
			else which = 3'($urandom_range(7, 1));
			load_pattern(which[0], which[1], which[2], bytes_all[63:0], bytes_all[127:64],
				len_word);

			steady_flow = (phase == 2);
			if (phase == 6) hold_request = 1'b1;
			len = board.active_length();
			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_BYTES) begin
				if (phase == 4 && !paused && sent >= PHASE_BYTES / 2) begin
					settle();
					paused = 1'b1;
				end
				pick = $urandom_range(99);
				if (pick < 40) span = len;
				else if (pick < 60) span = $urandom_range(len, 1);
				else span = 0;
				if (span > 0) begin
					for (int j = 0; j < span; j++) begin
						send_byte(board.pattern_at(j), $urandom_range(99) < START_PERCENT);
						sent++;
					end
				end else begin
					if (pick < 85) b = board.pattern_at($urandom_range(len - 1));
					else b = 8'($urandom_range(255));
					send_byte(b, $urandom_range(99) < START_PERCENT);
					sent++;
				end
			end
		end
		steady_flow = 1'b0;
		settle();

		$display("Streamed %0d text bytes over %0d register writes; %0d results checked,",
			board.noted, reg_writes, board.checked);
		$display("%0d of them matches, with zero, overlong and cut lengths and stalls.",
			board.found);
		if (board.mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches found.", board.mismatches);
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
